/* rtl/cfb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cfb_pkg;

	localparam int QueueDepth = 4;

	// steps of the back-end byte sequencer
	localparam logic [4:0] StepHdrFirst = 5'd0;
	localparam logic [4:0] StepLenHi    = 5'd8;
	localparam logic [4:0] StepLenLo    = 5'd9;
	localparam logic [4:0] StepHdrCk    = 5'd10;
	localparam logic [4:0] StepPw0      = 5'd11;
	localparam logic [4:0] StepPw1      = 5'd12;
	localparam logic [4:0] StepPw2      = 5'd13;
	localparam logic [4:0] StepPw3      = 5'd14;
	localparam logic [4:0] StepPayload  = 5'd15;
	localparam logic [4:0] StepClose    = 5'd16;

	localparam logic [7:0] HdrSumFixed = 8'h73;
	localparam logic [7:0] LenExtra    = 8'd5;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [7:0] frame_length;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
	} out_word_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic        is_start;
		logic [7:0]  len_lo;
		logic [7:0]  hck;
		logic [31:0] pw;
		logic [7:0]  pb;
		logic        has_pb;
		logic        close;
		logic [7:0]  cks;
	} desc_t;

	function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0: b = 8'hF1;
			3'd1: b = 8'h1F;
			3'd2: b = 8'hE2;
			3'd3: b = 8'h2E;
			3'd4: b = 8'hB6;
			3'd5: b = 8'h6B;
			3'd6: b = 8'hA8;
			3'd7: b = 8'h8A;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

/* rtl/command_frame_builder_core.sv */
// Command frame builder: wraps payload bytes into a module command frame.
// Input side is a queue write: present in_word and raise push; the word is
// taken at a clock edge where push is high and full is low. The first word
// of a frame supplies frame_length; each word carries one payload byte.
// Result side is a queue read: while empty is low, out_word holds the next
// frame byte, and it is taken at an edge where pop is high.
// A frame-start word yields 16 bytes (17 when the length is one): header,
// length, header checksum, password, its payload byte (none at length zero),
// and the closing checksum when due. Later words yield one, two on the last.
// The first byte of a word passes through the descriptor queue and the
// output register before it is on out_word. The byte sequencer emits one
// byte per cycle unless pop is low with a word waiting; a 4-entry
// descriptor queue lets new words be taken while the sequencer is busy.
// The password register is sampled on the frame-start word.
// Reset clears frame state, the queue and the output valid flag; the
// password resets to zero. While pop is low with a word waiting, the output
// word holds, the sequencer stops, and push is refused once the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module command_frame_builder_core #(
	parameter int QUEUE_DEPTH = cfb_pkg::QueueDepth
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire cfb_pkg::in_word_t  in_word,
	output logic                    empty,
	input  wire logic               pop,
	output cfb_pkg::out_word_t      out_word,
	input  wire logic               cfg_wr_en,
	input  wire logic [31:0]        cfg_wr_data
);
	import cfb_pkg::*;

	logic [31:0] password_q;
	logic        accept;
	desc_t       front_desc;
	desc_t       head_desc;
	logic        head_empty;
	logic        head_pop;

	// hold the password register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			password_q <= 32'd0;
		end else if (cfg_wr_en) begin
			password_q <= cfg_wr_data;
		end
	end

	assign accept = push && !full;

	cfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_word  (in_word),
		.password (password_q),
		.desc     (front_desc)
	);

	cfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wdata  (front_desc),
		.full   (full),
		.rd     (head_pop),
		.rdata  (head_desc),
		.empty  (head_empty)
	);

	cfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_desc),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.out_word   (out_word)
	);

endmodule
`default_nettype wire

/* rtl/cfb_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module cfb_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire cfb_pkg::in_word_t in_word,
	input  wire logic [31:0]     password,
	output cfb_pkg::desc_t       desc
);
	import cfb_pkg::*;

	logic       in_frame_q;
	logic [7:0] bytes_left_q;
	logic [7:0] sum_q;

	logic [7:0] pw_sum;
	logic [7:0] base_sum;
	logic [7:0] new_sum;
	logic [7:0] len_lo;
	logic [7:0] left_next;
	logic       zero_len;

	// classify the item and work out its checksums
	always_comb begin
		len_lo   = in_word.frame_length + LenExtra;
		pw_sum   = password[31:24] + password[23:16] + password[15:8] + password[7:0];
		zero_len = !in_frame_q && (in_word.frame_length == 8'd0);
		base_sum = in_frame_q ? sum_q : pw_sum;
		new_sum  = zero_len ? pw_sum : base_sum + in_word.payload_byte;
		left_next = (in_frame_q ? bytes_left_q : in_word.frame_length) - 8'd1;

		desc.is_start = !in_frame_q;
		desc.len_lo   = len_lo;
		desc.hck      = 8'd0 - (HdrSumFixed + len_lo);
		desc.pw       = password;
		desc.pb       = in_word.payload_byte;
		desc.has_pb   = !zero_len;
		desc.close    = zero_len || (left_next == 8'd0);
		desc.cks      = 8'd0 - new_sum;
	end

	// advance frame state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			bytes_left_q <= 8'd0;
			sum_q        <= 8'd0;
		end else if (accept) begin
			in_frame_q   <= !desc.close;
			bytes_left_q <= zero_len ? 8'd0 : left_next;
			sum_q        <= desc.close ? 8'd0 : new_sum;
		end
	end

endmodule
`default_nettype wire

/* rtl/cfb_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module cfb_queue #(
	parameter int DEPTH = cfb_pkg::QueueDepth
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr,
	input  wire cfb_pkg::desc_t wdata,
	output logic                full,
	input  wire logic           rd,
	output cfb_pkg::desc_t      rdata,
	output logic                empty
);
	import cfb_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	desc_t           slot_q [DEPTH];
	logic [PtrW-1:0] wptr_q;
	logic [PtrW-1:0] rptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntFull);
	assign empty = (count_q == '0);
	assign rdata = slot_q[rptr_q];

	// store incoming descriptors
	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
			end
			if (rd) begin
				rptr_q <= (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + CntW'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/cfb_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module cfb_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cfb_pkg::desc_t head,
	input  wire logic           head_empty,
	output logic                head_pop,
	output logic                empty,
	input  wire logic           pop,
	output cfb_pkg::out_word_t  out_word
);
	import cfb_pkg::*;

	logic       busy_q;
	logic [4:0] step_q;
	logic       out_valid_q;
	out_word_t  out_word_q;

	logic       advance;
	logic [4:0] cur_step;
	logic [4:0] end_step;
	out_word_t  next_word;

	// pick the byte for the current step
	always_comb begin
		advance  = !head_empty && (!out_valid_q || pop);
		cur_step = busy_q ? step_q : (head.is_start ? StepHdrFirst : StepPayload);
		end_step = (head.has_pb && head.close) ? StepClose : StepPayload;

		next_word.out_byte = 8'h00;
		priority if (cur_step < StepLenHi) begin
			next_word.out_byte = hdr_byte(cur_step[2:0]);
		end else if (cur_step == StepLenHi) begin
			next_word.out_byte = 8'h00;
		end else if (cur_step == StepLenLo) begin
			next_word.out_byte = head.len_lo;
		end else if (cur_step == StepHdrCk) begin
			next_word.out_byte = head.hck;
		end else if (cur_step == StepPw0) begin
			next_word.out_byte = head.pw[31:24];
		end else if (cur_step == StepPw1) begin
			next_word.out_byte = head.pw[23:16];
		end else if (cur_step == StepPw2) begin
			next_word.out_byte = head.pw[15:8];
		end else if (cur_step == StepPw3) begin
			next_word.out_byte = head.pw[7:0];
		end else if (cur_step == StepPayload) begin
			next_word.out_byte = head.has_pb ? head.pb : head.cks;
		end else begin
			next_word.out_byte = head.cks;
		end
		next_word.run_last  = (cur_step == end_step);
		next_word.frame_end = (cur_step == StepClose) ||
			((cur_step == StepPayload) && !head.has_pb);
		head_pop = advance && (cur_step == end_step);
	end

	// step through the descriptor at the queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= StepHdrFirst;
		end else if (advance) begin
			if (cur_step == end_step) begin
				busy_q <= 1'b0;
			end else begin
				busy_q <= 1'b1;
				step_q <= cur_step + 5'd1;
			end
		end
	end

	// hold the result word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= next_word;
		end
	end

	assign empty    = !out_valid_q;
	assign out_word = out_word_q;

endmodule
`default_nettype wire

/* sim/command_frame_builder_core_test.sv */
`timescale 1ns / 1ps
module command_frame_builder_core_test;

	localparam int HALF_PERIOD = 6;
	localparam int TARGET_WORDS = 410;
	localparam logic [7:0] LEN_PAD = 8'd5;
	localparam logic [7:0] SYNC_BYTES [8] = '{
		8'hF1, 8'h1F, 8'hE2, 8'h2E, 8'hB6, 8'h6B, 8'hA8, 8'h8A
	};

	// Tracks frame state and holds the frame bytes still owed by the block
	class frame_board;
		logic [31:0] password;
		bit in_frame;
		logic [7:0] bytes_left;
		logic [7:0] body_sum;
		cfb_pkg::out_word_t due_bytes[$];
		int unsigned mismatches;

		function new();
			password = '0;
			in_frame = 1'b0;
			bytes_left = '0;
			body_sum = '0;
			mismatches = 0;
		endfunction

		function void note_word(cfb_pkg::in_word_t w);
			cfb_pkg::out_word_t run[$];
			logic [7:0] len_lo;
			logic [7:0] hdr_sum;
			logic [7:0] hdr_ck;
			logic [7:0] pw_byte;
			logic [7:0] close_ck;
			// open a frame: sync bytes, length, header checksum, password
			if (!in_frame) begin
				hdr_sum = '0;
				for (int i = 0; i < 8; i++) begin
					run.push_back('{SYNC_BYTES[i], 1'b0, 1'b0});
					hdr_sum += SYNC_BYTES[i];
				end
				len_lo = w.frame_length + LEN_PAD;
				hdr_sum += len_lo;
				hdr_ck = 8'h00 - hdr_sum;
				run.push_back('{8'h00, 1'b0, 1'b0});
				run.push_back('{len_lo, 1'b0, 1'b0});
				run.push_back('{hdr_ck, 1'b0, 1'b0});
				body_sum = '0;
				for (int i = 0; i < 4; i++) begin
					pw_byte = password[31 - 8 * i -: 8];
					run.push_back('{pw_byte, 1'b0, 1'b0});
					body_sum += pw_byte;
				end
				// empty frame closes at once and ignores the payload byte
				if (w.frame_length == 8'd0) begin
					close_ck = 8'h00 - body_sum;
					run.push_back('{close_ck, 1'b0, 1'b1});
					body_sum = '0;
				end else begin
					bytes_left = w.frame_length;
					in_frame = 1'b1;
				end
			end
			// pass the payload byte, close the frame after its last one
			if (in_frame) begin
				run.push_back('{w.payload_byte, 1'b0, 1'b0});
				body_sum += w.payload_byte;
				bytes_left -= 8'd1;
				if (bytes_left == 8'd0) begin
					close_ck = 8'h00 - body_sum;
					run.push_back('{close_ck, 1'b0, 1'b1});
					in_frame = 1'b0;
					body_sum = '0;
				end
			end
			run[run.size() - 1].run_last = 1'b1;
			foreach (run[i])
				due_bytes.push_back(run[i]);
		endfunction

		function void check_byte(cfb_pkg::out_word_t got);
			cfb_pkg::out_word_t want;
			if (due_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: out_byte %h run_last %b frame_end %b",
						got.out_byte, got.run_last, got.frame_end);
				return;
			end
			want = due_bytes.pop_front();
			if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
					got.frame_end !== want.frame_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: out_byte %h/%h run_last %b/%b frame_end %b/%b",
						$time, want.out_byte, got.out_byte, want.run_last, got.run_last,
						want.frame_end, got.frame_end);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	cfb_pkg::in_word_t in_word = '0;
	logic full;
	logic empty;
	cfb_pkg::out_word_t out_word;

	frame_board board;
	bit quiet = 1'b0;
	int unsigned words_sent = 0;

	command_frame_builder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_word(in_word),
		.empty(empty),
		.pop(pop),
		.out_word(out_word),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// check every word taken from the result side
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			board.check_byte(out_word);
	end

	// mostly no gap, some short ones, a few long ones
	function int unsigned gap_len();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// drain results with random stalls
	initial begin
		int unsigned stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				stall = gap_len();
			end
		end
	end

	// present one word and hold it until taken
	task automatic send_word(cfb_pkg::in_word_t w);
		int unsigned gap;
		gap = gap_len();
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
		board.note_word(w);
		words_sent++;
	endtask

	// first word carries the length, later words random noise in frame_length
	task automatic send_frame(int unsigned len);
		cfb_pkg::in_word_t w;
		w.payload_byte = 8'($urandom_range(0, 255));
		w.frame_length = 8'(len);
		send_word(w);
		for (int k = 1; k < len; k++) begin
			w.payload_byte = 8'($urandom_range(0, 255));
			w.frame_length = 8'($urandom_range(0, 255));
			send_word(w);
		end
	endtask

	// drop push and wait until every owed word has come out
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (board.due_bytes.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_password(logic [31:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		board.password = value;
	endtask

	function int unsigned small_len();
		if ($urandom_range(0, 9) == 0)
			return 0;
		return $urandom_range(1, 24);
	endfunction

	initial begin
		cfb_pkg::in_word_t w;
		int unsigned phase;
		int unsigned phase_end;
		board = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty frame with the reset password; payload byte ignored
		w.payload_byte = 8'hFF;
		w.frame_length = 8'd0;
		send_word(w);
		settle();
		write_password(32'hFFFF_FFFF);
		// single-byte frames close on their first word
		w.payload_byte = 8'h00;
		w.frame_length = 8'd1;
		send_word(w);
		w.payload_byte = 8'hFF;
		send_word(w);
		w.payload_byte = 8'hA5;
		w.frame_length = 8'd0;
		send_word(w);
		// password change in the middle of a frame applies to the next one
		w.payload_byte = 8'h80;
		w.frame_length = 8'd3;
		send_word(w);
		settle();
		write_password(32'h1234_5678);
		w.payload_byte = 8'h7F;
		w.frame_length = 8'hFF;
		send_word(w);
		w.payload_byte = 8'h01;
		w.frame_length = 8'h00;
		send_word(w);
		w.payload_byte = 8'h55;
		w.frame_length = 8'd2;
		send_word(w);
		w.payload_byte = 8'hAA;
		send_word(w);

		// random frames in phases, one of them without any gaps
		phase = 0;
		while (words_sent < TARGET_WORDS) begin
			quiet = (phase == 1);
			phase_end = words_sent + 80;
			if (phase == 2)
				send_frame($urandom_range(250, 255));
			while (words_sent < phase_end && words_sent < TARGET_WORDS)
				send_frame(small_len());
			settle();
			case (phase % 3)
				0: write_password(32'h0000_0000);
				1: write_password(32'hFFFF_FFFF);
				default: write_password($urandom());
			endcase
			phase++;
		end

		settle();
		if (board.mismatches == 0 && board.due_bytes.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
